// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define SVSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge out of reset.
`define SVSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SVSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SVSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/svsp_pkg.sv
// ----------------------------------------------------------------------------
// svsp_pkg
// Constants, register indexes and the sine table builder of the servo profiler.
// ----------------------------------------------------------------------------
package svsp_pkg;

  localparam int POSITION_BITS_DEF    = 12;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  localparam int PHASE_BITS  = 14;
  localparam int PHASE_MAX   = 16383;
  localparam int STEP_BITS   = 12;
  localparam int STEP_MAX    = 4095;
  localparam int SPEED_BITS  = 16;
  localparam int SINE_BITS   = 15;
  localparam int OUT_POS_BITS = 12;

  localparam logic [15:0] SPEED_RESET = 16'd4096;
  localparam logic [15:0] TENTH_Q15   = 16'd3277;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_POSITION = 2'd0,
    CFG_STOP_POSITION  = 2'd1,
    CFG_SPEED_GAIN     = 2'd2
  } cfg_reg_t;

  // Q15 sine of a Q30 angle in [0, pi/2], Taylor series through the x^11 term,
  // rounded half up and saturated. Only ever evaluated on constants.
  function automatic logic [SINE_BITS-1:0] sine_q15_entry(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    term = x;
    sum  = signed'(x);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd6;
    sum  = sum - signed'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd20;
    sum  = sum + signed'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd42;
    sum  = sum - signed'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd72;
    sum  = sum + signed'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd110;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (unsigned'(sum) > ONE_Q30) begin
      sum = signed'(ONE_Q30);
    end
    q = (unsigned'(sum) + (64'd1 << 14)) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[SINE_BITS-1:0];
  endfunction

endpackage

// File: rtl/sine_velocity_servo_profiler_unit.sv
// ----------------------------------------------------------------------------
// sine_velocity_servo_profiler_unit
// One-axis servo move generator with a sine-shaped speed profile.
// ----------------------------------------------------------------------------
// Usage: every input transaction is one servo tick. in_abort = 1 ends any move
// and returns the phase to zero; in_abort = 0 advances the move by one step,
// starting a new move at start_position when none is active. Each tick yields
// exactly one output transaction with the new position, the step taken and
// the jumped_to_start, done_res and invalid flags.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) and must
// only be written while no tick is in flight.
// Flow: a moving tick passes through the divider state, in which a restoring
// divider that yields one quotient bit per cycle forms the sine angle, then one
// table read and two passes through a shared 32x16 multiplier, and then the
// commit state, from which the result is registered. Abort and invalid ticks go
// straight to the commit state. One tick is worked on at a time, and the
// sequencer returns to idle as its result is registered. in_ready is high
// whenever the sequencer is idle, even while a finished result waits in the
// output register; a stalled receiver only holds the sequencer in its final
// commit state.
// Reset (synchronous, rst_n low) clears the axis position, the phase and the
// move flag, and loads start 0, stop 0 and speed gain 1.0.
// SINE_TABLE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module sine_velocity_servo_profiler_unit
  import svsp_pkg::*;
#(
  parameter int POSITION_BITS    = POSITION_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // tick input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_abort,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_POS_BITS-1:0]  out_position,
  output logic [STEP_BITS-1:0]     out_step_size,
  output logic                     out_jumped_to_start,
  output logic                     out_done_res,
  output logic                     out_invalid,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

`include "assert_macros.svh"

  // Table offset bits, angle index bits (a full circle is 4*DEPTH units) and
  // the width of the divider numerator travelled*4*DEPTH + d.
  localparam int TW   = $clog2(SINE_TABLE_DEPTH);
  localparam int IDXW = TW + 2;
  localparam int NW   = PHASE_BITS + IDXW + 1;
  localparam int CNTW = $clog2(NW + 1);
  localparam int NPW  = ((POSITION_BITS > STEP_BITS) ? POSITION_BITS : STEP_BITS) + 1;
  localparam int MULA = 32;
  localparam int MULP = MULA + SPEED_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LUT,
    S_MUL1,
    S_MUL2,
    S_COMMIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [POSITION_BITS-1:0] start_r;
  logic [POSITION_BITS-1:0] stop_r;
  logic [SPEED_BITS-1:0]    speed_r;

  // Axis state.
  logic [POSITION_BITS-1:0] axis_r;
  logic [PHASE_BITS-1:0]    travelled_r;
  logic                     active_r;

  // Per-tick working registers.
  logic                     abort_r;
  logic                     bad_r;
  logic                     jumped_r;
  logic                     zero_r;
  logic [NW-1:0]            num_r;
  logic [POSITION_BITS:0]   rem_r;
  logic [IDXW-1:0]          quot_r;
  logic [CNTW-1:0]          cnt_r;
  logic [SINE_BITS-1:0]     sin_mag_r;
  logic                     sin_neg_r;
  logic [MULP-1:0]          prod_r;

  // Output register.
  logic                     out_valid_r;
  logic [OUT_POS_BITS-1:0]  out_position_r;
  logic [STEP_BITS-1:0]     out_step_r;
  logic                     out_jumped_r;
  logic                     out_done_r;
  logic                     out_invalid_r;

  // ------------------------------------------------------------------------
  // Quarter-wave sine table, built at elaboration.
  // ------------------------------------------------------------------------
  logic [SINE_BITS-1:0] sine_tbl [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    assign sine_tbl[k] = sine_q15_entry(ANGLE);
  end

  // ------------------------------------------------------------------------
  // Combinational helpers.
  // ------------------------------------------------------------------------
  logic                     in_fire;
  logic                     commit_go;
  logic                     move_up;
  logic [POSITION_BITS-1:0] span;
  logic                     jump_nxt;
  logic [PHASE_BITS-1:0]    trav_start;
  logic [NW-1:0]            num_nxt;

  assign in_fire   = in_valid && in_ready;
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  assign move_up   = start_r < stop_r;
  assign span      = move_up ? (stop_r - start_r) : (start_r - stop_r);
  assign jump_nxt  = !in_abort && !active_r;
  assign trav_start = jump_nxt ? '0 : travelled_r;
  assign num_nxt   = {1'b0, trav_start, {IDXW{1'b0}}} + NW'(span);

  // Restoring divider, one quotient bit per cycle; the divisor is 2*d.
  logic [POSITION_BITS+1:0] rem_sh;
  logic [POSITION_BITS+1:0] divisor;
  logic                     div_ge;
  logic [POSITION_BITS+1:0] rem_sub;

  assign rem_sh  = {rem_r, num_r[NW-1]};
  assign divisor = {1'b0, span, 1'b0};
  assign div_ge  = rem_sh >= divisor;
  assign rem_sub = rem_sh - divisor;

  // Quadrant decode of the angle index.
  logic [TW-1:0] tbl_off;
  logic [TW:0]   tbl_idx;

  assign tbl_off = quot_r[TW-1:0];
  assign tbl_idx = quot_r[TW] ? ((TW+1)'(SINE_TABLE_DEPTH) - {1'b0, tbl_off})
                              : {1'b0, tbl_off};

  // Sine plus one tenth; non-positive sums give no step.
  logic [15:0] s_val;
  logic        s_nonpos;

  assign s_val    = sin_neg_r ? (TENTH_Q15 - 16'(sin_mag_r)) : (TENTH_Q15 + 16'(sin_mag_r));
  assign s_nonpos = sin_neg_r && (16'(sin_mag_r) >= TENTH_Q15);

  // Shared multiplier: (s * d) first, then times the speed gain.
  logic [MULA-1:0]       mul_a;
  logic [SPEED_BITS-1:0] mul_b;
  logic [MULP-1:0]       mul_p;

  assign mul_a = (state_r == S_MUL2) ? prod_r[MULA-1:0] : MULA'(s_val);
  assign mul_b = (state_r == S_MUL2) ? speed_r : SPEED_BITS'(span);
  assign mul_p = mul_a * mul_b;

  // Round the Q27 product half up and saturate to the step range.
  logic [MULP:0]            rnd_sum;
  logic [MULP-27:0]         rnd_int;
  logic [STEP_BITS-1:0]     step_nxt;

  assign rnd_sum  = {1'b0, prod_r} + ((MULP+1)'(1) << 26);
  assign rnd_int  = rnd_sum[MULP:27];
  assign step_nxt = (zero_r || abort_r || bad_r) ? '0
                  : (rnd_int > (MULP-26)'(STEP_MAX)) ? STEP_BITS'(STEP_MAX)
                  : rnd_int[STEP_BITS-1:0];

  // Phase accumulation with saturation.
  logic [PHASE_BITS:0]   trav_sum;
  logic [PHASE_BITS-1:0] trav_nxt;

  assign trav_sum = {1'b0, travelled_r} + (PHASE_BITS+1)'(step_nxt);
  assign trav_nxt = (trav_sum > (PHASE_BITS+1)'(PHASE_MAX)) ? PHASE_BITS'(PHASE_MAX)
                                                          : trav_sum[PHASE_BITS-1:0];

  // Move toward stop and detect arrival (reaching or passing stop).
  logic [NPW-1:0]           axis_e;
  logic [NPW-1:0]           stop_e;
  logic [NPW-1:0]           step_e;
  logic [NPW-1:0]           up_sum;
  logic [NPW-1:0]           down_diff;
  logic [NPW-1:0]           stop_plus;
  logic                     done_nxt;
  logic [POSITION_BITS-1:0] axis_nxt;

  assign axis_e    = NPW'(axis_r);
  assign stop_e    = NPW'(stop_r);
  assign step_e    = NPW'(step_nxt);
  assign up_sum    = axis_e + step_e;
  assign down_diff = axis_e - step_e;
  assign stop_plus = stop_e + step_e;
  assign done_nxt  = move_up ? (up_sum >= stop_e) : (axis_e <= stop_plus);
  assign axis_nxt  = done_nxt ? stop_r
                   : move_up ? up_sum[POSITION_BITS-1:0] : down_diff[POSITION_BITS-1:0];

  // ------------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      stop_r  <= '0;
      speed_r <= SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_START_POSITION: start_r <= cfg_data[POSITION_BITS-1:0];
        CFG_STOP_POSITION:  stop_r  <= cfg_data[POSITION_BITS-1:0];
        CFG_SPEED_GAIN:     speed_r <= cfg_data[SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Sequencer, axis state and output register.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      travelled_r <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A committed result refills the output register in the same cycle
      // that the previous one leaves.
      if (commit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            abort_r  <= in_abort;
            jumped_r <= jump_nxt;
            bad_r    <= !in_abort && (span == '0);
            zero_r   <= 1'b0;
            num_r    <= num_nxt;
            rem_r    <= '0;
            quot_r   <= '0;
            cnt_r    <= '0;
            if (jump_nxt) begin
              // A new move begins: the axis jumps to start and the phase restarts.
              active_r    <= 1'b1;
              travelled_r <= '0;
              axis_r      <= start_r;
            end
            if (in_abort || (span == '0)) begin
              state_r <= S_COMMIT;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          num_r  <= {num_r[NW-2:0], 1'b0};
          rem_r  <= div_ge ? rem_sub[POSITION_BITS:0] : rem_sh[POSITION_BITS:0];
          quot_r <= {quot_r[IDXW-2:0], div_ge};
          cnt_r  <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(NW - 1)) begin
            state_r <= S_LUT;
          end
        end
        S_LUT: begin
          sin_mag_r <= sine_tbl[tbl_idx];
          sin_neg_r <= quot_r[IDXW-1];
          state_r   <= S_MUL1;
        end
        S_MUL1: begin
          zero_r  <= s_nonpos;
          prod_r  <= mul_p;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= mul_p;
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit_go) begin
            if (abort_r) begin
              active_r    <= 1'b0;
              travelled_r <= '0;
            end else if (!bad_r) begin
              axis_r <= axis_nxt;
              if (done_nxt) begin
                active_r    <= 1'b0;
                travelled_r <= '0;
              end else begin
                travelled_r <= trav_nxt;
              end
            end
            out_position_r <= (abort_r || bad_r) ? OUT_POS_BITS'(axis_r)
                                                 : OUT_POS_BITS'(axis_nxt);
            out_step_r     <= step_nxt;
            out_jumped_r   <= jumped_r;
            out_done_r     <= !abort_r && !bad_r && done_nxt;
            out_invalid_r  <= bad_r;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_position        = out_position_r;
  assign out_step_size       = out_step_r;
  assign out_jumped_to_start = out_jumped_r;
  assign out_done_res        = out_done_r;
  assign out_invalid         = out_invalid_r;

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------
  // An accepted tick always leaves the sequencer busy in the cycle after it is taken.
  `SVSP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)
  // An invalid result never moves the axis or finishes a move.
  `SVSP_ASSERT_IMPL(a_invalid_no_step, clk, rst_n, out_valid_r && out_invalid_r,
                    (out_step_r == '0) && !out_done_r)
  // A committed arrival ends the move and clears the phase.
  `SVSP_ASSERT_NEXT(a_done_ends_move, clk, rst_n, commit_go && !abort_r && !bad_r && done_nxt,
                    !active_r && (travelled_r == '0) && (axis_r == stop_r))
  // The divider never runs past the numerator width.
  `SVSP_ASSERT_IMPL(a_div_count, clk, rst_n, state_r == S_DIV, cnt_r < CNTW'(NW))

endmodule
